/* sv/tbrl_pkg.sv */
// ----------------------------------------------------------------------------
// tbrl_pkg
// Shared types and constants for the tile binning reference list unit.
// ----------------------------------------------------------------------------
package tbrl_pkg;

  localparam int MAX_SPLATS    = 1024;
  localparam int MAX_GRID_SIDE = 64;
  localparam int TILE_SLOTS    = MAX_GRID_SIDE * MAX_GRID_SIDE;
  localparam int MAX_REFS      = 16384;

  localparam int SPLAT_W = $clog2(MAX_SPLATS);
  localparam int LOAD_W  = SPLAT_W + 1;
  localparam int SIDE_W  = 7;
  localparam int COORD_W = 6;
  localparam int TILE_W  = $clog2(TILE_SLOTS);
  localparam int TCNT_W  = TILE_W + 1;
  localparam int REF_W   = $clog2(MAX_REFS);
  localparam int OFS_W   = REF_W + 1;
  localparam int CNT_W   = 11;
  localparam int AREA_W  = 2 * COORD_W + 1;
  localparam int RECT_W  = 4 * COORD_W;
  localparam int CFG_IDX_W = 2;

  typedef enum logic [1:0] {
    KIND_LOAD  = 2'd0,
    KIND_TILE  = 2'd1,
    KIND_ENTRY = 2'd2,
    KIND_NONE  = 2'd3
  } kind_t;

  typedef enum logic [2:0] {
    ST_OK          = 3'd0,
    ST_OUT_OF_GRID = 3'd1,
    ST_INVERTED    = 3'd2,
    ST_OVERFLOW    = 3'd3,
    ST_TOO_MANY    = 3'd4,
    ST_QUERY_BAD   = 3'd5
  } status_t;

  localparam logic [CFG_IDX_W-1:0] CFG_COLUMNS = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_ROWS    = 2'd1;

  typedef enum logic [4:0] {
    S_INIT, S_IDLE, S_DECODE, S_LD_PREP, S_LD_CHECK, S_LD_RD, S_LD_WR,
    S_PS_RD, S_PS_WR, S_PS_END, S_SC_RECT, S_SC_LOAD, S_SC_RD, S_SC_WR,
    S_Q1_RD0, S_Q1_RD1, S_Q1_FIN, S_Q2_RD, S_Q2_FIN, S_RESP
  } state_t;

  typedef struct packed {
    logic in_ready;
    logic clr_step;
    logic res_clear;
    logic res_bad;
    logic prep;
    logic check;
    logic tile_rd;
    logic tile_wr;
    logic ps_start;
    logic ps_rd;
    logic ps_wr;
    logic ps_end;
    logic sc_rect;
    logic sc_load;
    logic sc_rd;
    logic sc_wr;
    logic sc_next;
    logic finish;
    logic q1_rd0;
    logic q1_rd1;
    logic q1_fin;
    logic q2_rd;
    logic q2_fin;
    logic push;
  } cmd_t;

  typedef struct packed {
    logic  in_fire;
    logic  clr_last;
    kind_t kind;
    logic  final_splat;
    logic  q1_bad;
    logic  q2_bad;
    logic  load_ok;
    logic  tile_last;
    logic  tiles_zero;
    logic  ps_last;
    logic  no_splats;
    logic  s_last;
    logic  out_free;
  } stat_t;

endpackage

/* sv/tbrl_if.sv */
// ----------------------------------------------------------------------------
// tbrl_if
// Request, result and configuration channels.
// ----------------------------------------------------------------------------
interface tbrl_in_if;
  logic        valid;
  logic        ready;
  logic [1:0]  kind;
  logic [5:0]  column_first;
  logic [5:0]  column_final;
  logic [5:0]  row_first;
  logic [5:0]  row_final;
  logic        final_splat;
  logic [11:0] tile_query;
  logic [13:0] list_position;
  modport source(output valid, kind, column_first, column_final, row_first, row_final,
                 final_splat, tile_query, list_position, input ready);
  modport sink(input valid, kind, column_first, column_final, row_first, row_final,
               final_splat, tile_query, list_position, output ready);
endinterface

interface tbrl_out_if;
  logic        valid;
  logic        ready;
  logic [2:0]  status;
  logic        binning_done;
  logic [14:0] tile_offset;
  logic [10:0] tile_count;
  logic [9:0]  splat_number;
  logic [14:0] total_references;
  logic [10:0] peak_per_tile;
  modport source(output valid, status, binning_done, tile_offset, tile_count, splat_number,
                 total_references, peak_per_tile, input ready);
  modport sink(input valid, status, binning_done, tile_offset, tile_count, splat_number,
               total_references, peak_per_tile, output ready);
endinterface

interface tbrl_cfg_if;
  logic       valid;
  logic       ready;
  logic [1:0] index;
  logic [6:0] data;
  modport source(output valid, index, data, input ready);
  modport sink(input valid, index, data, output ready);
endinterface

/* sv/tbrl_ctrl.sv */
// ----------------------------------------------------------------------------
// tbrl_ctrl
// Sequencer for load, prefix sum, scatter and query requests.
// ----------------------------------------------------------------------------
module tbrl_ctrl (
  input  logic            clk,
  input  logic            rst_n,
  input  tbrl_pkg::stat_t stat,
  output tbrl_pkg::cmd_t  cmd
);

  tbrl_pkg::state_t state_r, state_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= tbrl_pkg::S_INIT;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_comb begin
    tbrl_pkg::state_t after_load;
    after_load = tbrl_pkg::S_RESP;
    if (stat.final_splat) begin
      after_load = stat.tiles_zero ? tbrl_pkg::S_PS_END : tbrl_pkg::S_PS_RD;
    end
    cmd = '0;
    state_nxt = state_r;
    case (state_r)
      tbrl_pkg::S_INIT: begin
        cmd.clr_step = 1'b1;
        if (stat.clr_last) state_nxt = tbrl_pkg::S_IDLE;
      end
      tbrl_pkg::S_IDLE: begin
        cmd.in_ready = 1'b1;
        if (stat.in_fire) state_nxt = tbrl_pkg::S_DECODE;
      end
      tbrl_pkg::S_DECODE: begin
        cmd.res_clear = 1'b1;
        case (stat.kind)
          tbrl_pkg::KIND_LOAD: state_nxt = tbrl_pkg::S_LD_PREP;
          tbrl_pkg::KIND_TILE: begin
            cmd.res_bad = stat.q1_bad;
            state_nxt = stat.q1_bad ? tbrl_pkg::S_RESP : tbrl_pkg::S_Q1_RD0;
          end
          tbrl_pkg::KIND_ENTRY: begin
            cmd.res_bad = stat.q2_bad;
            state_nxt = stat.q2_bad ? tbrl_pkg::S_RESP : tbrl_pkg::S_Q2_RD;
          end
          default: begin
            cmd.res_bad = 1'b1;
            state_nxt = tbrl_pkg::S_RESP;
          end
        endcase
      end
      tbrl_pkg::S_LD_PREP: begin
        cmd.prep = 1'b1;
        state_nxt = tbrl_pkg::S_LD_CHECK;
      end
      tbrl_pkg::S_LD_CHECK: begin
        cmd.check = 1'b1;
        cmd.ps_start = 1'b1;
        state_nxt = stat.load_ok ? tbrl_pkg::S_LD_RD : after_load;
      end
      tbrl_pkg::S_LD_RD: begin
        cmd.tile_rd = 1'b1;
        state_nxt = tbrl_pkg::S_LD_WR;
      end
      tbrl_pkg::S_LD_WR: begin
        cmd.tile_wr = 1'b1;
        state_nxt = stat.tile_last ? after_load : tbrl_pkg::S_LD_RD;
      end
      tbrl_pkg::S_PS_RD: begin
        cmd.ps_rd = 1'b1;
        state_nxt = tbrl_pkg::S_PS_WR;
      end
      tbrl_pkg::S_PS_WR: begin
        cmd.ps_wr = 1'b1;
        state_nxt = stat.ps_last ? tbrl_pkg::S_PS_END : tbrl_pkg::S_PS_RD;
      end
      tbrl_pkg::S_PS_END: begin
        cmd.ps_end = 1'b1;
        if (stat.no_splats) begin
          cmd.finish = 1'b1;
          state_nxt = tbrl_pkg::S_RESP;
        end else begin
          state_nxt = tbrl_pkg::S_SC_RECT;
        end
      end
      tbrl_pkg::S_SC_RECT: begin
        cmd.sc_rect = 1'b1;
        state_nxt = tbrl_pkg::S_SC_LOAD;
      end
      tbrl_pkg::S_SC_LOAD: begin
        cmd.sc_load = 1'b1;
        state_nxt = tbrl_pkg::S_SC_RD;
      end
      tbrl_pkg::S_SC_RD: begin
        cmd.sc_rd = 1'b1;
        state_nxt = tbrl_pkg::S_SC_WR;
      end
      tbrl_pkg::S_SC_WR: begin
        cmd.sc_wr = 1'b1;
        if (!stat.tile_last) begin
          state_nxt = tbrl_pkg::S_SC_RD;
        end else if (stat.s_last) begin
          cmd.finish = 1'b1;
          state_nxt = tbrl_pkg::S_RESP;
        end else begin
          cmd.sc_next = 1'b1;
          state_nxt = tbrl_pkg::S_SC_RECT;
        end
      end
      tbrl_pkg::S_Q1_RD0: begin
        cmd.q1_rd0 = 1'b1;
        state_nxt = tbrl_pkg::S_Q1_RD1;
      end
      tbrl_pkg::S_Q1_RD1: begin
        cmd.q1_rd1 = 1'b1;
        state_nxt = tbrl_pkg::S_Q1_FIN;
      end
      tbrl_pkg::S_Q1_FIN: begin
        cmd.q1_fin = 1'b1;
        state_nxt = tbrl_pkg::S_RESP;
      end
      tbrl_pkg::S_Q2_RD: begin
        cmd.q2_rd = 1'b1;
        state_nxt = tbrl_pkg::S_Q2_FIN;
      end
      tbrl_pkg::S_Q2_FIN: begin
        cmd.q2_fin = 1'b1;
        state_nxt = tbrl_pkg::S_RESP;
      end
      tbrl_pkg::S_RESP: begin
        if (stat.out_free) begin
          cmd.push = 1'b1;
          state_nxt = tbrl_pkg::S_IDLE;
        end
      end
      default: state_nxt = tbrl_pkg::S_INIT;
    endcase
  end

endmodule

/* sv/tbrl_dp.sv */
// ----------------------------------------------------------------------------
// tbrl_dp
// Datapath: grid registers, tile counts, offsets, cursors and reference list.
// ----------------------------------------------------------------------------
module tbrl_dp (
  input  logic            clk,
  input  logic            rst_n,
  tbrl_in_if.sink         in_ch,
  tbrl_out_if.source      out_ch,
  tbrl_cfg_if.sink        cfg_ch,
  input  tbrl_pkg::cmd_t  cmd,
  output tbrl_pkg::stat_t stat
);

  localparam int TW  = tbrl_pkg::TILE_W;
  localparam int TCW = tbrl_pkg::TCNT_W;
  localparam int CW  = tbrl_pkg::COORD_W;
  localparam int SW  = tbrl_pkg::SIDE_W;
  localparam int OW  = tbrl_pkg::OFS_W;
  localparam int NW  = tbrl_pkg::CNT_W;
  localparam int PW  = tbrl_pkg::SPLAT_W;
  localparam int LW  = tbrl_pkg::LOAD_W;
  localparam int RW  = tbrl_pkg::REF_W;
  localparam int AW  = tbrl_pkg::AREA_W;

  logic [tbrl_pkg::RECT_W-1:0] rect_mem [tbrl_pkg::MAX_SPLATS];
  logic [NW-1:0]               cnt_mem  [tbrl_pkg::TILE_SLOTS];
  logic [OW-1:0]               ofs_mem  [tbrl_pkg::TILE_SLOTS + 1];
  logic [OW-1:0]               cur_mem  [tbrl_pkg::TILE_SLOTS];
  logic [PW-1:0]               list_mem [tbrl_pkg::MAX_REFS];

  logic [SW-1:0] grid_cols_r, grid_rows_r, set_cols_r, set_rows_r;
  logic [TCW-1:0] tiles_r;
  logic [TW-1:0] clr_r;
  tbrl_pkg::kind_t kind_r;
  logic [CW-1:0] cf_r, cl_r, rf_r, rl_r;
  logic final_r;
  logic [TW-1:0] tq_r;
  logic [RW-1:0] pos_r;
  logic [AW-1:0] area_r;
  logic [LW-1:0] loaded_r;
  logic [OW-1:0] total_r;
  logic [NW-1:0] peak_r;
  logic done_r;
  logic [CW-1:0] wc_r, wr_r, wcf_r, wcl_r, wrl_r;
  logic [TW-1:0] rowbase_r;
  logic [TCW-1:0] t_r;
  logic [OW-1:0] acc_r;
  logic [PW-1:0] s_r;
  logic [tbrl_pkg::RECT_W-1:0] rect_rd_r;
  logic [NW-1:0] cnt_rd_r;
  logic [OW-1:0] ofs_rd_r, cur_rd_r, ofs0_r;
  logic [PW-1:0] list_rd_r;
  tbrl_pkg::status_t res_status_r;
  logic [OW-1:0] res_ofs_r;
  logic [NW-1:0] res_cnt_r;
  logic [PW-1:0] res_num_r;
  logic out_valid_r;

  logic [TW-1:0] tile_addr;
  logic [NW-1:0] cnt_inc;
  tbrl_pkg::status_t ld_status;
  logic [OW:0] total_sum;
  logic [CW:0] cw, rh;
  logic [CW-1:0] m_cf, m_cl, m_rf, m_rl;

  assign tile_addr = rowbase_r + TW'(wc_r);
  assign cnt_inc   = cnt_rd_r + 1'b1;
  assign cfg_ch.ready = 1'b1;
  assign in_ch.ready = cmd.in_ready;
  assign {m_rl, m_rf, m_cl, m_cf} = rect_rd_r;

  always_comb begin
    cw = {1'b0, cl_r} - {1'b0, cf_r} + 1'b1;
    rh = {1'b0, rl_r} - {1'b0, rf_r} + 1'b1;
    total_sum = {1'b0, total_r} + (OW+1)'(area_r);
    if ({1'b0, cf_r} >= set_cols_r || {1'b0, cl_r} >= set_cols_r ||
        {1'b0, rf_r} >= set_rows_r || {1'b0, rl_r} >= set_rows_r) begin
      ld_status = tbrl_pkg::ST_OUT_OF_GRID;
    end else if (cf_r > cl_r || rf_r > rl_r) begin
      ld_status = tbrl_pkg::ST_INVERTED;
    end else if (loaded_r == LW'(tbrl_pkg::MAX_SPLATS)) begin
      ld_status = tbrl_pkg::ST_TOO_MANY;
    end else if (total_sum > (OW+1)'(tbrl_pkg::MAX_REFS)) begin
      ld_status = tbrl_pkg::ST_OVERFLOW;
    end else begin
      ld_status = tbrl_pkg::ST_OK;
    end
  end

  always_comb begin
    stat.in_fire     = in_ch.valid && cmd.in_ready;
    stat.clr_last    = (clr_r == '1);
    stat.kind        = kind_r;
    stat.final_splat = final_r;
    stat.q1_bad      = !done_r || ({1'b0, tq_r} >= tiles_r);
    stat.q2_bad      = !done_r || ({1'b0, pos_r} >= total_r);
    stat.load_ok     = (ld_status == tbrl_pkg::ST_OK);
    stat.tile_last   = (wc_r == wcl_r) && (wr_r == wrl_r);
    stat.tiles_zero  = (tiles_r == '0);
    stat.ps_last     = (t_r == tiles_r - 1'b1);
    stat.no_splats   = (loaded_r == '0);
    stat.s_last      = ({1'b0, s_r} == loaded_r - 1'b1);
    stat.out_free    = !out_valid_r || out_ch.ready;
  end

  // configuration and control registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      grid_cols_r <= SW'(16);
      grid_rows_r <= SW'(16);
      set_cols_r  <= '0;
      set_rows_r  <= '0;
      tiles_r     <= '0;
      clr_r       <= '0;
      loaded_r    <= '0;
      total_r     <= '0;
      peak_r      <= '0;
      done_r      <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      if (cfg_ch.valid) begin
        if (cfg_ch.index == tbrl_pkg::CFG_COLUMNS) grid_cols_r <= cfg_ch.data;
        if (cfg_ch.index == tbrl_pkg::CFG_ROWS)    grid_rows_r <= cfg_ch.data;
      end
      if (cmd.clr_step) clr_r <= clr_r + 1'b1;
      if (cmd.prep) begin
        if (done_r) begin
          loaded_r <= '0;
          total_r  <= '0;
          peak_r   <= '0;
          done_r   <= 1'b0;
        end
        if (done_r || loaded_r == '0) begin
          set_cols_r <= (grid_cols_r > SW'(tbrl_pkg::MAX_GRID_SIDE)) ?
                        SW'(tbrl_pkg::MAX_GRID_SIDE) : grid_cols_r;
          set_rows_r <= (grid_rows_r > SW'(tbrl_pkg::MAX_GRID_SIDE)) ?
                        SW'(tbrl_pkg::MAX_GRID_SIDE) : grid_rows_r;
          tiles_r    <= TCW'(
            ((grid_cols_r > SW'(tbrl_pkg::MAX_GRID_SIDE)) ?
             SW'(tbrl_pkg::MAX_GRID_SIDE) : grid_cols_r) *
            ((grid_rows_r > SW'(tbrl_pkg::MAX_GRID_SIDE)) ?
             SW'(tbrl_pkg::MAX_GRID_SIDE) : grid_rows_r));
        end
      end
      if (cmd.check && ld_status == tbrl_pkg::ST_OK) begin
        loaded_r <= loaded_r + 1'b1;
        total_r  <= total_sum[OW-1:0];
      end
      if (cmd.tile_wr && cnt_inc > peak_r) peak_r <= cnt_inc;
      if (cmd.finish) done_r <= 1'b1;
      if (cmd.push) begin
        out_valid_r <= 1'b1;
      end else if (out_ch.ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  // request capture, walkers and results
  always_ff @(posedge clk) begin
    if (stat.in_fire) begin
      kind_r  <= tbrl_pkg::kind_t'(in_ch.kind);
      cf_r    <= in_ch.column_first;
      cl_r    <= in_ch.column_final;
      rf_r    <= in_ch.row_first;
      rl_r    <= in_ch.row_final;
      final_r <= in_ch.final_splat;
      tq_r    <= in_ch.tile_query;
      pos_r   <= in_ch.list_position;
    end
    if (cmd.prep) area_r <= AW'(cw * rh);
    if (cmd.check) begin
      wc_r      <= cf_r;
      wr_r      <= rf_r;
      wcf_r     <= cf_r;
      wcl_r     <= cl_r;
      wrl_r     <= rl_r;
      rowbase_r <= TW'(rf_r * set_cols_r);
    end
    if (cmd.sc_load) begin
      wc_r      <= m_cf;
      wr_r      <= m_rf;
      wcf_r     <= m_cf;
      wcl_r     <= m_cl;
      wrl_r     <= m_rl;
      rowbase_r <= TW'(m_rf * set_cols_r);
    end
    if (cmd.tile_wr || cmd.sc_wr) begin
      if (wc_r == wcl_r) begin
        wc_r      <= wcf_r;
        wr_r      <= wr_r + 1'b1;
        rowbase_r <= rowbase_r + TW'(set_cols_r);
      end else begin
        wc_r <= wc_r + 1'b1;
      end
    end
    if (cmd.ps_start) begin
      t_r   <= '0;
      acc_r <= '0;
      s_r   <= '0;
    end
    if (cmd.ps_wr) begin
      t_r   <= t_r + 1'b1;
      acc_r <= acc_r + OW'(cnt_rd_r);
    end
    if (cmd.sc_next) s_r <= s_r + 1'b1;
    if (cmd.res_clear) begin
      res_status_r <= cmd.res_bad ? tbrl_pkg::ST_QUERY_BAD : tbrl_pkg::ST_OK;
      res_ofs_r    <= '0;
      res_cnt_r    <= '0;
      res_num_r    <= '0;
    end
    if (cmd.check) res_status_r <= ld_status;
    if (cmd.q1_rd1) ofs0_r <= ofs_rd_r;
    if (cmd.q1_fin) begin
      res_ofs_r <= ofs0_r;
      res_cnt_r <= NW'(ofs_rd_r - ofs0_r);
    end
    if (cmd.q2_fin) res_num_r <= list_rd_r;
    if (cmd.push) begin
      out_ch.status           <= res_status_r;
      out_ch.binning_done     <= done_r;
      out_ch.tile_offset      <= res_ofs_r;
      out_ch.tile_count       <= res_cnt_r;
      out_ch.splat_number     <= res_num_r;
      out_ch.total_references <= total_r;
      out_ch.peak_per_tile    <= peak_r;
    end
  end

  assign out_ch.valid = out_valid_r;

  // memories
  always_ff @(posedge clk) begin
    if (cmd.check && ld_status == tbrl_pkg::ST_OK) begin
      rect_mem[loaded_r[PW-1:0]] <= {rl_r, rf_r, cl_r, cf_r};
    end
    if (cmd.sc_rect) rect_rd_r <= rect_mem[s_r];
  end

  always_ff @(posedge clk) begin
    if (cmd.clr_step) begin
      cnt_mem[clr_r] <= '0;
    end else if (cmd.tile_wr) begin
      cnt_mem[tile_addr] <= cnt_inc;
    end else if (cmd.ps_wr) begin
      cnt_mem[t_r[TW-1:0]] <= '0;
    end
    cnt_rd_r <= cnt_mem[cmd.ps_rd ? t_r[TW-1:0] : tile_addr];
  end

  always_ff @(posedge clk) begin
    if (cmd.ps_wr || cmd.ps_end) ofs_mem[t_r] <= acc_r;
    if (cmd.q1_rd0 || cmd.q1_rd1) begin
      ofs_rd_r <= ofs_mem[cmd.q1_rd1 ? ({1'b0, tq_r} + 1'b1) : {1'b0, tq_r}];
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.ps_wr) begin
      cur_mem[t_r[TW-1:0]] <= acc_r;
    end else if (cmd.sc_wr) begin
      cur_mem[tile_addr] <= cur_rd_r + 1'b1;
    end
    cur_rd_r <= cur_mem[tile_addr];
  end

  always_ff @(posedge clk) begin
    if (cmd.sc_wr) list_mem[cur_rd_r[RW-1:0]] <= s_r;
    if (cmd.q2_rd) list_rd_r <= list_mem[pos_r];
  end

endmodule

/* sv/tile_binning_reference_lists_unit.sv */
// ----------------------------------------------------------------------------
// tile_binning_reference_lists_unit
// Bins splat rectangles into screen tiles by counting sort and answers queries.
// ----------------------------------------------------------------------------
// Load: after accept the splat is decoded, prepared and checked, then each covered
//   tile count is read and written (none when dropped); a final load adds the prefix
//   sum over every tile of the grid plus, for each kept splat, the scatter over its area.
// Queries: a rejected one goes straight to the result, a list entry reads once, a tile
//   reads two offsets, plus any output stall; one request in flight at a time.
// Reset: a clearing pass over all 4096 tile counts zeroes them; no request is
//   accepted during it, configuration writes are taken throughout.
module tile_binning_reference_lists_unit (
  input logic        clk,
  input logic        rst_n,
  tbrl_in_if.sink    in_ch,
  tbrl_out_if.source out_ch,
  tbrl_cfg_if.sink   cfg_ch
);

  tbrl_pkg::cmd_t  cmd;
  tbrl_pkg::stat_t stat;

  tbrl_ctrl u_ctrl (
    .clk   (clk),
    .rst_n (rst_n),
    .stat  (stat),
    .cmd   (cmd)
  );

  tbrl_dp u_dp (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_ch  (in_ch),
    .out_ch (out_ch),
    .cfg_ch (cfg_ch),
    .cmd    (cmd),
    .stat   (stat)
  );

endmodule

/* tb/tbrl_checker.sv */
// ----------------------------------------------------------------------------
// tbrl_checker
// Watches the request, result and configuration channels of the tile binning
// unit, keeps its own counting-sort copy of the binning state, works out the
// answer to every accepted request and compares each result field by field.
// ----------------------------------------------------------------------------
module tbrl_checker (
  input  logic clk,
  input  logic rst_n,
  tbrl_in_if   in_mon,
  tbrl_out_if  out_mon,
  tbrl_cfg_if  cfg_mon,
  output int   fail_count,
  output int   answers_due
);
  timeunit 1ns;
  timeprecision 1ps;

  typedef struct {
    tbrl_pkg::status_t status;
    bit                done;
    int unsigned       offset;
    int unsigned       count;
    int unsigned       number;
    int unsigned       total;
    int unsigned       peak;
  } answer_t;

  answer_t answer_q[$];

  int unsigned columns_reg, rows_reg, set_cols, set_rows;
  int unsigned kept_splats, ref_total, peak_count;
  bit          binned;
  logic [tbrl_pkg::RECT_W-1:0] rect_mem[tbrl_pkg::MAX_SPLATS];
  int unsigned tile_cnt[tbrl_pkg::TILE_SLOTS];
  int unsigned tile_ofs[tbrl_pkg::TILE_SLOTS+1];
  int unsigned cursor[tbrl_pkg::TILE_SLOTS];
  int unsigned ref_list[tbrl_pkg::MAX_REFS];

  task automatic report(string field, int unsigned got, int unsigned want);
    $display("%0t mismatch on %s: got %0d, expected %0d", $realtime, field, got, want);
    fail_count++;
  endtask

  function automatic int unsigned clamp_side(int unsigned v);
    return v > tbrl_pkg::MAX_GRID_SIDE ? tbrl_pkg::MAX_GRID_SIDE : v;
  endfunction

  task automatic build_lists();
    int unsigned tiles, t, s, r, c, cf, cl, rf, rl;
    tiles = set_cols * set_rows;
    tile_ofs[0] = 0;
    for (t = 0; t < tiles; t++) begin
      tile_ofs[t+1] = tile_ofs[t] + tile_cnt[t];
      cursor[t] = tile_ofs[t];
    end
    for (s = 0; s < kept_splats; s++) begin
      {rl, rf, cl, cf} = {26'd0, rect_mem[s][23:18], 26'd0, rect_mem[s][17:12],
                          26'd0, rect_mem[s][11:6], 26'd0, rect_mem[s][5:0]};
      for (r = rf; r <= rl; r++)
        for (c = cf; c <= cl; c++) begin
          t = r * set_cols + c;
          if (t < tiles && cursor[t] < tbrl_pkg::MAX_REFS) begin
            ref_list[cursor[t]] = s;
            cursor[t]++;
          end
        end
    end
    binned = 1;
  endtask

  function automatic tbrl_pkg::status_t bin_splat(int unsigned cf, int unsigned cl,
                                                  int unsigned rf, int unsigned rl);
    int unsigned area, r, c, t;
    if (binned) begin
      foreach (tile_cnt[i]) tile_cnt[i] = 0;
      kept_splats = 0;
      ref_total = 0;
      peak_count = 0;
      binned = 0;
    end
    if (kept_splats == 0) begin
      set_cols = clamp_side(columns_reg);
      set_rows = clamp_side(rows_reg);
    end
    if (cf >= set_cols || cl >= set_cols || rf >= set_rows || rl >= set_rows)
      return tbrl_pkg::ST_OUT_OF_GRID;
    if (cf > cl || rf > rl) return tbrl_pkg::ST_INVERTED;
    if (kept_splats >= tbrl_pkg::MAX_SPLATS) return tbrl_pkg::ST_TOO_MANY;
    area = (cl - cf + 1) * (rl - rf + 1);
    if (ref_total + area > tbrl_pkg::MAX_REFS) return tbrl_pkg::ST_OVERFLOW;
    rect_mem[kept_splats] = {rl[5:0], rf[5:0], cl[5:0], cf[5:0]};
    kept_splats++;
    ref_total += area;
    for (r = rf; r <= rl; r++)
      for (c = cf; c <= cl; c++) begin
        t = r * set_cols + c;
        tile_cnt[t]++;
        if (tile_cnt[t] > peak_count) peak_count = tile_cnt[t];
      end
    return tbrl_pkg::ST_OK;
  endfunction

  task automatic bin_request();
    answer_t a;
    int unsigned tile, pos;
    a = '{tbrl_pkg::ST_OK, 0, 0, 0, 0, 0, 0};
    case (tbrl_pkg::kind_t'(in_mon.kind))
      tbrl_pkg::KIND_LOAD: begin
        a.status = bin_splat(32'(in_mon.column_first), 32'(in_mon.column_final),
                             32'(in_mon.row_first), 32'(in_mon.row_final));
        if (in_mon.final_splat) build_lists();
      end
      tbrl_pkg::KIND_TILE: begin
        tile = 32'(in_mon.tile_query);
        if (!binned || tile >= set_cols * set_rows) a.status = tbrl_pkg::ST_QUERY_BAD;
        else begin
          a.offset = tile_ofs[tile];
          a.count  = tile_cnt[tile];
        end
      end
      tbrl_pkg::KIND_ENTRY: begin
        pos = 32'(in_mon.list_position);
        if (!binned || pos >= ref_total) a.status = tbrl_pkg::ST_QUERY_BAD;
        else a.number = ref_list[pos];
      end
      default: a.status = tbrl_pkg::ST_QUERY_BAD;
    endcase
    a.done  = binned;
    a.total = ref_total;
    a.peak  = peak_count;
    answer_q = {answer_q, a};
  endtask

  task automatic check_result();
    answer_t a;
    if (answer_q.size() == 0) begin
      $display("%0t unexpected result with status %0d", $realtime, out_mon.status);
      fail_count++;
      return;
    end
    a = answer_q.pop_front();
    if (out_mon.status !== a.status)
      report("status", 32'(out_mon.status), 32'(a.status));
    if (out_mon.binning_done !== a.done)
      report("binning_done", 32'(out_mon.binning_done), 32'(a.done));
    if (out_mon.tile_offset !== a.offset)
      report("tile_offset", 32'(out_mon.tile_offset), a.offset);
    if (out_mon.tile_count !== a.count)
      report("tile_count", 32'(out_mon.tile_count), a.count);
    if (out_mon.splat_number !== a.number)
      report("splat_number", 32'(out_mon.splat_number), a.number);
    if (out_mon.total_references !== a.total)
      report("total_references", 32'(out_mon.total_references), a.total);
    if (out_mon.peak_per_tile !== a.peak)
      report("peak_per_tile", 32'(out_mon.peak_per_tile), a.peak);
  endtask

  initial fail_count = 0;

  always @(posedge clk) begin
    if (!rst_n) begin
      columns_reg = 16;
      rows_reg    = 16;
      set_cols    = 0;
      set_rows    = 0;
      kept_splats = 0;
      ref_total   = 0;
      peak_count  = 0;
      binned      = 0;
      foreach (tile_cnt[i]) tile_cnt[i] = 0;
      answer_q.delete();
    end else begin
      if (cfg_mon.valid && cfg_mon.ready) begin
        if (cfg_mon.index == tbrl_pkg::CFG_COLUMNS) columns_reg = 32'(cfg_mon.data);
        else if (cfg_mon.index == tbrl_pkg::CFG_ROWS) rows_reg = 32'(cfg_mon.data);
      end
      if (out_mon.valid && out_mon.ready) check_result();
      if (in_mon.valid && in_mon.ready) bin_request();
    end
    answers_due = answer_q.size();
  end

endmodule

/* tb/tb_tile_binning_reference_lists_unit.sv */
// ----------------------------------------------------------------------------
// tb_tile_binning_reference_lists_unit
// Drives splat loads, tile and list queries and grid writes into the binning
// unit under several idle and stall mixes; the checker predicts and compares.
// ----------------------------------------------------------------------------
module tb_tile_binning_reference_lists_unit;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int CYCLE_LIMIT = 2_500_000;
  localparam int RANDOM_PER_PHASE = 105;

  logic clk = 1'b0;
  logic rst_n;
  int   fail_count, answers_due;
  int   cycles = 0;
  int   send_idle_pct = 0;
  int   recv_stall_pct = 0;
  int   sent = 0;
  int   grid_cols = 16;
  int   grid_rows = 16;

  tbrl_in_if  in_ch();
  tbrl_out_if out_ch();
  tbrl_cfg_if cfg_ch();

  tile_binning_reference_lists_unit i_dut (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_ch  (in_ch),
    .out_ch (out_ch),
    .cfg_ch (cfg_ch)
  );

  tbrl_checker i_checker (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_mon      (in_ch),
    .out_mon     (out_ch),
    .cfg_mon     (cfg_ch),
    .fail_count  (fail_count),
    .answers_due (answers_due)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > CYCLE_LIMIT) begin
      $display("timeout after %0d cycles", cycles);
      $display("*** FAILED ***");
      $finish;
    end
  end

  always @(negedge clk) out_ch.ready <= ($urandom_range(0, 99) >= recv_stall_pct);

  task automatic send(tbrl_pkg::kind_t kind, int cf, int cl, int rf, int rl, bit fin,
                      int tile, int pos);
    if ($urandom_range(0, 99) < send_idle_pct) begin
      in_ch.valid <= 1'b0;
      repeat ($urandom_range(1, 4)) @(negedge clk);
    end
    in_ch.valid         <= 1'b1;
    in_ch.kind          <= kind;
    in_ch.column_first  <= cf[5:0];
    in_ch.column_final  <= cl[5:0];
    in_ch.row_first     <= rf[5:0];
    in_ch.row_final     <= rl[5:0];
    in_ch.final_splat   <= fin;
    in_ch.tile_query    <= tile[11:0];
    in_ch.list_position <= pos[13:0];
    do @(posedge clk); while (!in_ch.ready);
    @(negedge clk);
    sent++;
  endtask

  task automatic load(int cf, int cl, int rf, int rl, bit fin);
    send(tbrl_pkg::KIND_LOAD, cf, cl, rf, rl, fin, $urandom, $urandom);
  endtask

  task automatic ask_tile(int tile);
    send(tbrl_pkg::KIND_TILE, $urandom, $urandom, $urandom, $urandom, 1'($urandom),
         tile, $urandom);
  endtask

  task automatic ask_entry(int pos);
    send(tbrl_pkg::KIND_ENTRY, $urandom, $urandom, $urandom, $urandom, 1'($urandom),
         $urandom, pos);
  endtask

  task automatic drain();
    in_ch.valid <= 1'b0;
    while (answers_due != 0) @(negedge clk);
    repeat (20) @(negedge clk);
  endtask

  task automatic write_grid(logic [tbrl_pkg::CFG_IDX_W-1:0] idx, int value);
    cfg_ch.valid <= 1'b1;
    cfg_ch.index <= idx;
    cfg_ch.data  <= value[6:0];
    do @(posedge clk); while (!cfg_ch.ready);
    @(negedge clk);
    cfg_ch.valid <= 1'b0;
    if (idx == tbrl_pkg::CFG_COLUMNS)
      grid_cols = value > tbrl_pkg::MAX_GRID_SIDE ? tbrl_pkg::MAX_GRID_SIDE : value;
    else
      grid_rows = value > tbrl_pkg::MAX_GRID_SIDE ? tbrl_pkg::MAX_GRID_SIDE : value;
  endtask

  function automatic int pick_side();
    case ($urandom_range(0, 19))
      0: return 0;
      1: return 64;
      2: return 127;
      3: return $urandom_range(65, 126);
      default: return $urandom_range(1, 8);
    endcase
  endfunction

  task automatic run_set();
    int n, m, c0, r0, gc, gr, kind;
    drain();
    if ($urandom_range(0, 1)) write_grid(tbrl_pkg::CFG_COLUMNS, pick_side());
    if ($urandom_range(0, 1)) write_grid(tbrl_pkg::CFG_ROWS, pick_side());
    gc = grid_cols;
    gr = grid_rows;
    n = $urandom_range(1, 20);
    for (int i = 0; i < n; i++) begin
      if (i == n / 2 && $urandom_range(0, 7) == 0) begin
        drain();
        write_grid($urandom_range(0, 1) ? tbrl_pkg::CFG_COLUMNS : tbrl_pkg::CFG_ROWS,
                   pick_side());
      end
      if ($urandom_range(0, 9) == 0 || gc == 0 || gr == 0)
        send(tbrl_pkg::kind_t'($urandom_range(0, 3)), $urandom, $urandom, $urandom,
             $urandom, i == n - 1, $urandom, $urandom);
      else begin
        c0 = $urandom_range(0, gc - 1);
        r0 = $urandom_range(0, gr - 1);
        load(c0, (c0 + $urandom_range(0, 3) < gc) ? c0 + $urandom_range(0, 3) : gc - 1,
             r0, (r0 + $urandom_range(0, 3) < gr) ? r0 + $urandom_range(0, 3) : gr - 1,
             i == n - 1);
      end
    end
    m = $urandom_range(2, 10);
    for (int i = 0; i < m; i++) begin
      kind = $urandom_range(0, 9);
      if (kind < 5)
        ask_tile((kind < 4 && gc * gr > 0) ? $urandom_range(0, gc * gr - 1)
                                           : $urandom_range(0, 4095));
      else if (kind < 9)
        ask_entry(kind < 8 ? $urandom_range(0, 60) : $urandom_range(0, 16383));
      else
        send(tbrl_pkg::KIND_NONE, $urandom, $urandom, $urandom, $urandom, 1'($urandom),
             $urandom, $urandom);
    end
  endtask

  initial begin
    rst_n               = 1'b0;
    in_ch.valid         = 1'b0;
    in_ch.kind          = tbrl_pkg::KIND_LOAD;
    in_ch.column_first  = '0;
    in_ch.column_final  = '0;
    in_ch.row_first     = '0;
    in_ch.row_final     = '0;
    in_ch.final_splat   = 1'b0;
    in_ch.tile_query    = '0;
    in_ch.list_position = '0;
    cfg_ch.valid        = 1'b0;
    cfg_ch.index        = tbrl_pkg::CFG_COLUMNS;
    cfg_ch.data         = '0;
    out_ch.ready        = 1'b0;
    repeat (6) @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    write_grid(tbrl_pkg::CFG_COLUMNS, 4);
    write_grid(tbrl_pkg::CFG_ROWS, 3);
    ask_tile(0);
    ask_entry(0);
    send(tbrl_pkg::KIND_NONE, 63, 63, 63, 63, 1, 4095, 16383);
    load(4, 4, 0, 0, 0);
    load(0, 0, 1, 3, 0);
    load(2, 1, 0, 0, 0);
    load(0, 3, 0, 2, 0);
    load(3, 3, 2, 2, 0);
    drain();
    write_grid(tbrl_pkg::CFG_COLUMNS, 2);
    load(1, 3, 1, 1, 0);
    load(63, 63, 63, 63, 1);
    ask_tile(0);
    ask_tile(11);
    ask_tile(12);
    ask_tile(4095);
    ask_entry(0);
    ask_entry(15);
    ask_entry(16);
    ask_entry(16383);
    send(tbrl_pkg::KIND_NONE, 0, 0, 0, 0, 0, 0, 0);
    load(0, 1, 0, 0, 1);
    drain();
    write_grid(tbrl_pkg::CFG_COLUMNS, 0);
    load(0, 0, 0, 0, 1);
    drain();
    write_grid(tbrl_pkg::CFG_COLUMNS, 127);
    write_grid(tbrl_pkg::CFG_ROWS, 64);
    for (int i = 0; i < 5; i++) load(0, 63, 0, 63, i == 4);
    ask_entry(16383);
    ask_tile(4095);

    for (int phase = 0; phase < 4; phase++) begin
      drain();
      case (phase)
        0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
        1: begin send_idle_pct = 72; recv_stall_pct = 0;  end
        2: begin send_idle_pct = 0;  recv_stall_pct = 72; end
        default: begin send_idle_pct = 32; recv_stall_pct = 32; end
      endcase
      if (phase == 3) begin
        drain();
        write_grid(tbrl_pkg::CFG_COLUMNS, 1);
        write_grid(tbrl_pkg::CFG_ROWS, 1);
        for (int i = 0; i < 1026; i++) load(0, 0, 0, 0, i == 1025);
        ask_entry(1023);
        ask_tile(0);
      end
      sent = 0;
      while (sent < RANDOM_PER_PHASE) run_set();
    end

    drain();
    repeat (50) @(negedge clk);
    if (fail_count == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("*** FAILED ***");
    end
    $finish;
  end

endmodule
